>>> design/path_direction_dtw_cost_assert.svh
// Assertion macros used by the checker file.
`ifndef PATH_DIRECTION_DTW_COST_ASSERT_SVH
`define PATH_DIRECTION_DTW_COST_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define PDC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdc assertion failed");

// Next-cycle implication.
`define PDC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdc assertion failed");

`endif

>>> design/pdc_pkg.sv
`default_nettype none
package pdc_pkg;

    // Node counts are held at the width that covers the largest path size.
    localparam int CNT_W       = 9;
    localparam int COORD_W     = 24;
    localparam int HEAD_W      = 16;
    localparam int COST_W      = 32;
    localparam int K_W         = COST_W + CNT_W;
    localparam int K_LO_W      = 24;
    localparam logic [COST_W-1:0] BORDER_COST = 32'd256000000;
    localparam logic [COST_W-1:0] COST_MAX    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic signed [COORD_W-1:0] node_x;
        logic signed [COORD_W-1:0] node_y;
        logic signed [COORD_W-1:0] node_z;
        logic                      last_node;
    } node_t;

    typedef struct packed {
        logic [COST_W-1:0] warp_cost;
        logic              overflow;
    } result_t;

    typedef struct packed {
        logic [COST_W-1:0] length_sum;
        logic [CNT_W-1:0]  count;
        logic              overflow;
    } job_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] robot_pos_x;
        logic signed [COORD_W-1:0] robot_pos_y;
        logic signed [HEAD_W-1:0]  heading_x;
        logic signed [HEAD_W-1:0]  heading_y;
    } cfg_t;

    typedef enum logic [1:0] {
        REG_ROBOT_X,
        REG_ROBOT_Y,
        REG_HEADING_X,
        REG_HEADING_Y
    } reg_idx_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_DIV,
        B_INIT,
        B_READ,
        B_MUL_LO,
        B_MUL_HI,
        B_ACC,
        B_REF,
        B_DIFF,
        B_SQ,
        B_SQSUM,
        B_ROOT,
        B_UPD,
        B_DONE
    } back_state_t;

endpackage
`default_nettype wire

>>> design/pdc_ram.sv
`default_nettype none
module pdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> design/pdc_front.sv
`default_nettype none
module pdc_front #(
    parameter int MAX_NODES = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          node_valid,
    input  wire pdc_pkg::node_t                node,
    output logic                               node_ready,
    output logic                               job_valid,
    output pdc_pkg::job_t                      job,
    input  wire logic                          job_ready,
    input  wire logic                          done,
    output logic                               st_we,
    output logic [$clog2(MAX_NODES)-1:0]       st_waddr,
    output logic [2*pdc_pkg::COORD_W-1:0]      st_wdata
);

    localparam int AW    = $clog2(MAX_NODES);
    localparam int D_W   = pdc_pkg::COORD_W + 1;
    localparam int SQ_W  = 2 * pdc_pkg::COORD_W + 1;
    localparam int SV_W  = SQ_W + 1;
    localparam int STEPS = SV_W / 2;

    logic                              busy_reg;
    logic [pdc_pkg::CNT_W-1:0]         count_reg;
    logic                              ovf_reg;
    logic [pdc_pkg::COST_W-1:0]        len_reg;
    logic signed [pdc_pkg::COORD_W-1:0] prev_x_reg, prev_y_reg, prev_z_reg;

    logic            s0_valid_reg, s0_add_reg, s0_last_reg;
    logic [SQ_W-1:0] sqx_reg, sqy_reg, sqz_reg;

    logic [SV_W-1:0] v_reg    [STEPS+1];
    logic [SV_W-1:0] r_reg    [STEPS+1];
    logic            pv_reg   [STEPS+1];
    logic            padd_reg [STEPS+1];
    logic            plast_reg[STEPS+1];
    logic [SV_W-1:0] v_next   [STEPS];
    logic [SV_W-1:0] r_next   [STEPS];

    logic                       accept, keep;
    logic signed [D_W-1:0]      dx, dy, dz;
    logic signed [2*D_W-1:0]    pxx, pyy, pzz;
    logic [pdc_pkg::COST_W:0]   len_sum;
    logic [pdc_pkg::COST_W-1:0] len_new;
    logic                       end_valid;

    assign node_ready = !busy_reg && job_ready;
    assign accept     = node_valid && node_ready;
    assign keep       = count_reg < pdc_pkg::CNT_W'(MAX_NODES);

    assign st_we    = accept && keep;
    assign st_waddr = count_reg[AW-1:0];
    assign st_wdata = {node.node_x, node.node_y};

    assign dx  = D_W'(node.node_x) - D_W'(prev_x_reg);
    assign dy  = D_W'(node.node_y) - D_W'(prev_y_reg);
    assign dz  = D_W'(node.node_z) - D_W'(prev_z_reg);
    assign pxx = dx * dx;
    assign pyy = dy * dy;
    assign pzz = dz * dz;

    // One root bit per stage; the trial bit of stage k sits at 2*(STEPS-1-k).
    always_comb
    begin
        logic [SV_W-1:0] b;
        logic [SV_W-1:0] t;
        for (int k = 0; k < STEPS; k++)
        begin
            b = SV_W'(1) << (2 * (STEPS - 1 - k));
            t = r_reg[k] + b;
            if (v_reg[k] >= t)
            begin
                v_next[k] = v_reg[k] - t;
                r_next[k] = (r_reg[k] >> 1) + b;
            end
            else
            begin
                v_next[k] = v_reg[k];
                r_next[k] = r_reg[k] >> 1;
            end
        end
    end

    assign end_valid = pv_reg[STEPS];
    assign len_sum   = {1'b0, len_reg} + {1'b0, r_reg[STEPS][pdc_pkg::COST_W-1:0]};
    assign len_new   = !padd_reg[STEPS] ? len_reg :
                       (len_sum[pdc_pkg::COST_W] ? pdc_pkg::COST_MAX :
                        len_sum[pdc_pkg::COST_W-1:0]);

    assign job_valid      = end_valid && plast_reg[STEPS];
    assign job.length_sum = len_new;
    assign job.count      = count_reg;
    assign job.overflow   = ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            len_reg      <= '0;
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
            prev_z_reg   <= '0;
            s0_valid_reg <= 1'b0;
            for (int k = 0; k <= STEPS; k++)
            begin
                pv_reg[k] <= 1'b0;
            end
        end
        else
        begin
            s0_valid_reg <= accept;
            pv_reg[0]    <= s0_valid_reg;
            for (int k = 0; k < STEPS; k++)
            begin
                pv_reg[k+1] <= pv_reg[k];
            end

            if (accept)
            begin
                if (keep)
                begin
                    count_reg  <= count_reg + 1'b1;
                    prev_x_reg <= node.node_x;
                    prev_y_reg <= node.node_y;
                    prev_z_reg <= node.node_z;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
                if (node.last_node)
                begin
                    busy_reg <= 1'b1;
                end
            end

            if (end_valid && !job_valid)
            begin
                len_reg <= len_new;
            end

            if (job_valid)
            begin
                count_reg  <= '0;
                ovf_reg    <= 1'b0;
                len_reg    <= '0;
                prev_x_reg <= '0;
                prev_y_reg <= '0;
                prev_z_reg <= '0;
            end

            if (done)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s0_add_reg   <= keep && (count_reg != '0);
        s0_last_reg  <= node.last_node;
        sqx_reg      <= pxx[SQ_W-1:0];
        sqy_reg      <= pyy[SQ_W-1:0];
        sqz_reg      <= pzz[SQ_W-1:0];
        v_reg[0]     <= SV_W'(sqx_reg) + SV_W'(sqy_reg) + SV_W'(sqz_reg);
        r_reg[0]     <= '0;
        padd_reg[0]  <= s0_add_reg;
        plast_reg[0] <= s0_last_reg;
        for (int k = 0; k < STEPS; k++)
        begin
            v_reg[k+1]     <= v_next[k];
            r_reg[k+1]     <= r_next[k];
            padd_reg[k+1]  <= padd_reg[k];
            plast_reg[k+1] <= plast_reg[k];
        end
    end

endmodule
`default_nettype wire

>>> design/pdc_queue.sv
`default_nettype none
module pdc_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    input  wire pdc_pkg::job_t push_data,
    output logic               push_ready,
    output logic               pop_valid,
    output pdc_pkg::job_t      pop_data,
    input  wire logic          pop_ready
);

    pdc_pkg::job_t ent_reg [2];
    logic          wptr_reg, rptr_reg;
    logic [1:0]    fill_reg;
    logic          do_push, do_pop;

    assign push_ready = fill_reg != 2'd2;
    assign pop_valid  = fill_reg != 2'd0;
    assign pop_data   = ent_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (do_pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

>>> design/pdc_back.sv
`default_nettype none
module pdc_back #(
    parameter int MAX_NODES = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pdc_pkg::cfg_t                 cfg,
    input  wire logic                          job_valid,
    input  wire pdc_pkg::job_t                 job,
    output logic                               job_ready,
    output logic                               st_re,
    output logic [$clog2(MAX_NODES)-1:0]       st_raddr,
    input  wire logic [2*pdc_pkg::COORD_W-1:0] st_rdata,
    output logic                               cost_valid,
    input  wire logic                          cost_ready,
    output pdc_pkg::result_t                   cost,
    output logic                               done
);

    localparam int AW    = $clog2(MAX_NODES);
    localparam int CW    = pdc_pkg::CNT_W;
    localparam int KW    = pdc_pkg::K_W;
    localparam int KLO   = pdc_pkg::K_LO_W;
    localparam int HW    = pdc_pkg::HEAD_W;
    localparam int PL_W  = HW + KLO + 1;
    localparam int PH_W  = HW + KW - KLO + 1;
    localparam int P_W   = PH_W + KLO + 1;
    localparam int OFF_W = P_W - 14;
    localparam int RX_W  = OFF_W + 1;
    localparam int DX_W  = RX_W + 1;
    localparam int CSW   = pdc_pkg::COST_W;

    pdc_pkg::back_state_t state_reg, state_next;

    logic [CW-1:0]   n_reg;
    logic            ovf_reg;
    logic [CSW-1:0]  q_reg;
    logic [CW-1:0]   rem_reg;
    logic [4:0]      step_reg;
    logic [AW-1:0]   i_reg, j_reg;
    logic [KW-1:0]   k_reg;
    logic [CSW-1:0]  diag_reg, left_reg, up_reg;
    logic signed [pdc_pkg::COORD_W-1:0] nx_reg, ny_reg;
    logic signed [PL_W-1:0]  plx_reg, ply_reg;
    logic signed [PH_W-1:0]  phx_reg, phy_reg;
    logic signed [OFF_W-1:0] offx_reg, offy_reg;
    logic signed [RX_W-1:0]  rx_reg, ry_reg;
    logic signed [CSW-1:0]   dxc_reg, dyc_reg;
    logic [63:0]     sqx_reg, sqy_reg, sv_reg, sr_reg, sb_reg;
    logic            cost_valid_reg;
    pdc_pkg::result_t cost_reg;

    logic            row_we, row_re;
    logic [CSW-1:0]  row_wdata, row_rdata;

    logic [CW:0]             rem_sh;
    logic                    q_bit;
    logic [CW-1:0]           n_m1;
    logic                    j_last, i_last;
    logic signed [PL_W-1:0]  plx_w, ply_w;
    logic signed [PH_W-1:0]  phx_w, phy_w;
    logic signed [P_W-1:0]   px_w, py_w;
    logic signed [DX_W-1:0]  dx_w, dy_w;
    logic signed [63:0]      sqx_w, sqy_w;
    logic [63:0]             root_t;
    logic [CSW-1:0]          m_min, cell_cost;
    logic [CSW:0]            cell_sum;
    logic                    out_free;

    function automatic logic signed [CSW-1:0] clamp_diff(input logic signed [DX_W-1:0] d);
        logic signed [DX_W-1:0] lim;
        lim = DX_W'(32'sh7FFF_FFFF);
        if (d > lim)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (d < -lim)
        begin
            return 32'sh8000_0001;
        end
        return d[CSW-1:0];
    endfunction

    assign n_m1   = n_reg - 1'b1;
    assign j_last = CW'(j_reg) == n_m1;
    assign i_last = CW'(i_reg) == n_m1;

    // Restoring division of the path length by the node count, one bit a cycle.
    assign rem_sh = {rem_reg, q_reg[CSW-1]};
    assign q_bit  = rem_sh >= {1'b0, n_reg};

    // The offset heading * k is split on k into two narrow products.
    assign plx_w = $signed(cfg.heading_x) * $signed({1'b0, k_reg[KLO-1:0]});
    assign ply_w = $signed(cfg.heading_y) * $signed({1'b0, k_reg[KLO-1:0]});
    assign phx_w = $signed(cfg.heading_x) * $signed({1'b0, k_reg[KW-1:KLO]});
    assign phy_w = $signed(cfg.heading_y) * $signed({1'b0, k_reg[KW-1:KLO]});
    assign px_w  = (P_W'(phx_reg) <<< KLO) + P_W'(plx_reg) + P_W'(8192);
    assign py_w  = (P_W'(phy_reg) <<< KLO) + P_W'(ply_reg) + P_W'(8192);
    assign dx_w  = DX_W'(nx_reg) - DX_W'(rx_reg);
    assign dy_w  = DX_W'(ny_reg) - DX_W'(ry_reg);
    assign sqx_w = dxc_reg * dxc_reg;
    assign sqy_w = dyc_reg * dyc_reg;
    assign root_t = sr_reg + sb_reg;

    always_comb
    begin
        m_min = (up_reg < left_reg) ? up_reg : left_reg;
        if (diag_reg < m_min)
        begin
            m_min = diag_reg;
        end
    end
    assign cell_sum  = {1'b0, sr_reg[CSW-1:0]} + {1'b0, m_min};
    assign cell_cost = cell_sum[CSW] ? pdc_pkg::COST_MAX : cell_sum[CSW-1:0];
    assign out_free  = !cost_valid_reg || cost_ready;

    assign st_re     = state_reg == pdc_pkg::B_READ;
    assign st_raddr  = i_reg;
    assign row_re    = state_reg == pdc_pkg::B_READ;
    assign row_wdata = (state_reg == pdc_pkg::B_INIT) ? pdc_pkg::BORDER_COST : cell_cost;

    always_comb
    begin
        state_next = state_reg;
        job_ready  = 1'b0;
        row_we     = 1'b0;
        done       = 1'b0;
        case (state_reg)
            pdc_pkg::B_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    state_next = pdc_pkg::B_DIV;
                end
            end
            pdc_pkg::B_DIV:
            begin
                if (step_reg == 5'd31)
                begin
                    state_next = pdc_pkg::B_INIT;
                end
            end
            pdc_pkg::B_INIT:
            begin
                row_we = 1'b1;
                if (j_last)
                begin
                    state_next = pdc_pkg::B_READ;
                end
            end
            pdc_pkg::B_READ:   state_next = pdc_pkg::B_MUL_LO;
            pdc_pkg::B_MUL_LO: state_next = pdc_pkg::B_MUL_HI;
            pdc_pkg::B_MUL_HI: state_next = pdc_pkg::B_ACC;
            pdc_pkg::B_ACC:    state_next = pdc_pkg::B_REF;
            pdc_pkg::B_REF:    state_next = pdc_pkg::B_DIFF;
            pdc_pkg::B_DIFF:   state_next = pdc_pkg::B_SQ;
            pdc_pkg::B_SQ:     state_next = pdc_pkg::B_SQSUM;
            pdc_pkg::B_SQSUM:  state_next = pdc_pkg::B_ROOT;
            pdc_pkg::B_ROOT:
            begin
                if (step_reg == 5'd31)
                begin
                    state_next = pdc_pkg::B_UPD;
                end
            end
            pdc_pkg::B_UPD:
            begin
                row_we = 1'b1;
                if (j_last && i_last)
                begin
                    state_next = pdc_pkg::B_DONE;
                end
                else
                begin
                    state_next = pdc_pkg::B_READ;
                end
            end
            pdc_pkg::B_DONE:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = pdc_pkg::B_IDLE;
                end
            end
            default: state_next = pdc_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pdc_pkg::B_IDLE;
            cost_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (done)
            begin
                cost_valid_reg <= 1'b1;
            end
            else if (cost_ready)
            begin
                cost_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            pdc_pkg::B_IDLE:
            begin
                n_reg    <= job.count;
                ovf_reg  <= job.overflow;
                q_reg    <= job.length_sum;
                rem_reg  <= '0;
                step_reg <= '0;
                j_reg    <= '0;
            end
            pdc_pkg::B_DIV:
            begin
                rem_reg  <= q_bit ? CW'(rem_sh - {1'b0, n_reg}) : rem_sh[CW-1:0];
                q_reg    <= {q_reg[CSW-2:0], q_bit};
                step_reg <= step_reg + 1'b1;
            end
            pdc_pkg::B_INIT:
            begin
                i_reg    <= '0;
                k_reg    <= '0;
                diag_reg <= '0;
                left_reg <= pdc_pkg::BORDER_COST;
                if (j_last)
                begin
                    j_reg <= '0;
                end
                else
                begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            pdc_pkg::B_READ:
            begin
                k_reg <= k_reg + KW'(q_reg);
            end
            pdc_pkg::B_MUL_LO:
            begin
                nx_reg  <= st_rdata[2*pdc_pkg::COORD_W-1:pdc_pkg::COORD_W];
                ny_reg  <= st_rdata[pdc_pkg::COORD_W-1:0];
                up_reg  <= row_rdata;
                plx_reg <= plx_w;
                ply_reg <= ply_w;
            end
            pdc_pkg::B_MUL_HI:
            begin
                phx_reg <= phx_w;
                phy_reg <= phy_w;
            end
            pdc_pkg::B_ACC:
            begin
                offx_reg <= px_w[P_W-1:14];
                offy_reg <= py_w[P_W-1:14];
            end
            pdc_pkg::B_REF:
            begin
                rx_reg <= RX_W'(cfg.robot_pos_x) + RX_W'(offx_reg);
                ry_reg <= RX_W'(cfg.robot_pos_y) + RX_W'(offy_reg);
            end
            pdc_pkg::B_DIFF:
            begin
                dxc_reg <= clamp_diff(dx_w);
                dyc_reg <= clamp_diff(dy_w);
            end
            pdc_pkg::B_SQ:
            begin
                sqx_reg <= sqx_w;
                sqy_reg <= sqy_w;
            end
            pdc_pkg::B_SQSUM:
            begin
                sv_reg   <= sqx_reg + sqy_reg;
                sr_reg   <= '0;
                sb_reg   <= 64'h4000_0000_0000_0000;
                step_reg <= '0;
            end
            pdc_pkg::B_ROOT:
            begin
                if (sv_reg >= root_t)
                begin
                    sv_reg <= sv_reg - root_t;
                    sr_reg <= (sr_reg >> 1) + sb_reg;
                end
                else
                begin
                    sr_reg <= sr_reg >> 1;
                end
                sb_reg   <= sb_reg >> 2;
                step_reg <= step_reg + 1'b1;
            end
            pdc_pkg::B_UPD:
            begin
                // The final cell stays in left_reg until the result register is free.
                if (j_last && !i_last)
                begin
                    j_reg    <= '0;
                    i_reg    <= i_reg + 1'b1;
                    k_reg    <= '0;
                    diag_reg <= pdc_pkg::BORDER_COST;
                    left_reg <= pdc_pkg::BORDER_COST;
                end
                else
                begin
                    j_reg    <= j_reg + 1'b1;
                    left_reg <= cell_cost;
                    diag_reg <= up_reg;
                end
            end
            pdc_pkg::B_DONE:
            begin
                if (out_free)
                begin
                    cost_reg.warp_cost <= left_reg;
                    cost_reg.overflow  <= ovf_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign cost_valid = cost_valid_reg;
    assign cost       = cost_reg;

    pdc_ram #(
        .WIDTH (CSW),
        .DEPTH (MAX_NODES)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (j_reg),
        .wdata (row_wdata),
        .re    (row_re),
        .raddr (j_reg),
        .rdata (row_rdata)
    );

endmodule
`default_nettype wire

>>> design/path_direction_dtw_cost.sv
// Channel   Direction  Payload                 Handshake
// node      in         node_x/y/z, last_node   node_valid / node_ready
// cost      out        warp_cost, overflow     cost_valid / cost_ready
// config    in         APB, 4 registers        psel / penable / pwrite / pready
//
// Nodes load at one per cycle while node_ready is high; the job of a path follows its
// last node through a 25-stage root pipeline for the segment lengths. The back end
// divides the path length by the node count for the spacing, presets the cost row and
// then works through the DTW cells in turn (a 32-step square root dominates). Nodes of
// the next path are taken once the result sits in the output register. Reset is
// asynchronous, active low.
`default_nettype none
module path_direction_dtw_cost #(
    parameter int MAX_NODES = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             node_valid,
    output logic                  node_ready,
    input  wire pdc_pkg::node_t   node,
    output logic                  cost_valid,
    input  wire logic             cost_ready,
    output pdc_pkg::result_t      cost,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [3:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int AW = $clog2(MAX_NODES);
    localparam int SW = 2 * pdc_pkg::COORD_W;

    pdc_pkg::cfg_t cfg_reg;
    pdc_pkg::job_t push_job, pop_job;
    logic          push_valid, push_ready, pop_valid, pop_ready, done;
    logic          st_we, st_re;
    logic [AW-1:0] st_waddr, st_raddr;
    logic [SW-1:0] st_wdata, st_rdata;
    logic          cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (pdc_pkg::reg_idx_t'(paddr[3:2]))
                pdc_pkg::REG_ROBOT_X:   cfg_reg.robot_pos_x <= pwdata[23:0];
                pdc_pkg::REG_ROBOT_Y:   cfg_reg.robot_pos_y <= pwdata[23:0];
                pdc_pkg::REG_HEADING_X: cfg_reg.heading_x   <= pwdata[15:0];
                pdc_pkg::REG_HEADING_Y: cfg_reg.heading_y   <= pwdata[15:0];
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (pdc_pkg::reg_idx_t'(paddr[3:2]))
            pdc_pkg::REG_ROBOT_X:   prdata = {8'd0, cfg_reg.robot_pos_x};
            pdc_pkg::REG_ROBOT_Y:   prdata = {8'd0, cfg_reg.robot_pos_y};
            pdc_pkg::REG_HEADING_X: prdata = {16'd0, cfg_reg.heading_x};
            pdc_pkg::REG_HEADING_Y: prdata = {16'd0, cfg_reg.heading_y};
            default:                prdata = '0;
        endcase
    end

    pdc_front #(
        .MAX_NODES (MAX_NODES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .node_valid (node_valid),
        .node       (node),
        .node_ready (node_ready),
        .job_valid  (push_valid),
        .job        (push_job),
        .job_ready  (push_ready),
        .done       (done),
        .st_we      (st_we),
        .st_waddr   (st_waddr),
        .st_wdata   (st_wdata)
    );

    pdc_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    pdc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_job),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_job),
        .pop_ready  (pop_ready)
    );

    pdc_back #(
        .MAX_NODES (MAX_NODES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .job_valid  (pop_valid),
        .job        (pop_job),
        .job_ready  (pop_ready),
        .st_re      (st_re),
        .st_raddr   (st_raddr),
        .st_rdata   (st_rdata),
        .cost_valid (cost_valid),
        .cost_ready (cost_ready),
        .cost       (cost),
        .done       (done)
    );

endmodule
`default_nettype wire

>>> design/pdc_checker.sv
`default_nettype none
`include "path_direction_dtw_cost_assert.svh"
module pdc_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             node_valid,
    input wire logic             node_ready,
    input wire pdc_pkg::node_t   node,
    input wire logic             cost_valid,
    input wire logic             cost_ready,
    input wire pdc_pkg::result_t cost,
    input wire logic             pready
);

    // A waiting result beat must hold its value.
    `PDC_ASSERT_NXT(a_cost_hold, cost_valid && !cost_ready, cost_valid && $stable(cost))
    // Taking the final node of a path drops node_ready.
    `PDC_ASSERT_NXT(a_path_lock, node_valid && node_ready && node.last_node, !node_ready)
    // A result beat cannot leave in the cycle right after the final node.
    `PDC_ASSERT_NXT(a_no_early, node_valid && node_ready && node.last_node,
                    !$rose(cost_valid))
    `PDC_ASSERT_IMP(a_pready, 1'b1, pready)

endmodule

bind path_direction_dtw_cost pdc_checker u_pdc_checker (.*);
`default_nettype wire

>>> sim/tb_path_direction_dtw_cost.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_path_direction_dtw_cost;

    localparam int MAX_PATH = 64;
    localparam int HOLD_OFF = 3000;
    localparam int STALL_LIMIT = 1000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic node_valid = 1'b0;
    logic node_ready;
    pdc_pkg::node_t node = '0;
    logic cost_valid;
    logic cost_ready = 1'b0;
    pdc_pkg::result_t cost;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    path_direction_dtw_cost #(.MAX_NODES(MAX_PATH)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .node_valid(node_valid), .node_ready(node_ready), .node(node),
        .cost_valid(cost_valid), .cost_ready(cost_ready), .cost(cost),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    pdc_pkg::node_t   nodes_to_send[$];
    pdc_pkg::result_t costs_due[$];

    // Shadow of the block's configuration and path state.
    longint pos_x, pos_y, dir_x, dir_y;
    longint path_x[MAX_PATH];
    longint path_y[MAX_PATH];
    longint prev_x, prev_y, prev_z;
    int unsigned stored_nodes;
    logic [31:0] path_length;
    logic extra_nodes;

    int mismatches = 0;
    int paths_sent = 0;
    int nodes_taken = 0;
    int costs_checked = 0;
    int quiet_cycles = 0;
    bit node_took = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? pdc_pkg::COST_MAX : s[31:0];
    endfunction

    function automatic longint round_q14(longint p);
        longint q;
        q = p + 8192;
        if (q >= 0)
            return q / 16384;
        return -((-q + 16383) / 16384);
    endfunction

    function automatic longint clamp31(longint d);
        if (d > 64'sd2147483647)
            return 64'sd2147483647;
        if (d < -64'sd2147483647)
            return -64'sd2147483647;
        return d;
    endfunction

    function automatic logic [31:0] warp_of_path();
        logic [31:0] row[MAX_PATH];
        logic [31:0] spacing, diag, left, up, m, seg_cost;
        longint k, rx, ry, dx, dy;
        for (int j = 0; j < stored_nodes; j++)
            row[j] = pdc_pkg::BORDER_COST;
        spacing = path_length / stored_nodes;
        for (int i = 0; i < stored_nodes; i++)
        begin
            diag = (i == 0) ? 32'd0 : pdc_pkg::BORDER_COST;
            left = pdc_pkg::BORDER_COST;
            for (int j = 0; j < stored_nodes; j++)
            begin
                k = longint'(spacing) * (j + 1);
                rx = pos_x + round_q14(dir_x * k);
                ry = pos_y + round_q14(dir_y * k);
                dx = clamp31(path_x[i] - rx);
                dy = clamp31(path_y[i] - ry);
                seg_cost = 32'(int_root(longint'(dx * dx) + longint'(dy * dy)));
                up = row[j];
                m = (up < left) ? up : left;
                if (diag < m)
                    m = diag;
                row[j] = add_sat(seg_cost, m);
                diag = up;
                left = row[j];
            end
        end
        return row[stored_nodes - 1];
    endfunction

    task automatic take_node(pdc_pkg::node_t n);
        longint x, y, z, dx, dy, dz;
        pdc_pkg::result_t r;
        x = longint'(n.node_x);
        y = longint'(n.node_y);
        z = longint'(n.node_z);
        if (stored_nodes >= MAX_PATH)
            extra_nodes = 1'b1;
        else
        begin
            if (stored_nodes > 0)
            begin
                dx = x - prev_x;
                dy = y - prev_y;
                dz = z - prev_z;
                path_length = add_sat(path_length,
                    32'(int_root(dx * dx + dy * dy + dz * dz)));
            end
            path_x[stored_nodes] = x;
            path_y[stored_nodes] = y;
            prev_x = x;
            prev_y = y;
            prev_z = z;
            stored_nodes++;
        end
        if (n.last_node)
        begin
            r.warp_cost = warp_of_path();
            r.overflow = extra_nodes;
            costs_due.insert(costs_due.size(), r);
            stored_nodes = 0;
            path_length = '0;
            prev_x = 0;
            prev_y = 0;
            prev_z = 0;
            extra_nodes = 1'b0;
        end
    endtask

    // Input side monitor, output checking and the stall watchdog.
    always @(posedge clk)
    begin
        node_took = node_valid && node_ready && rst_n;
        if (node_took)
        begin
            take_node(node);
            nodes_taken++;
        end
        if (cost_valid && cost_ready && rst_n)
        begin
            costs_checked++;
            if (costs_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected cost beat: cost=%0d overflow=%0b",
                             cost.warp_cost, cost.overflow);
            end
            else
            begin
                if (cost !== costs_due[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("cost mismatch: exp cost=%0d ovf=%0b got cost=%0d ovf=%0b",
                                 costs_due[0].warp_cost, costs_due[0].overflow,
                                 cost.warp_cost, cost.overflow);
                end
                void'(costs_due.pop_front());
            end
        end
        if (node_took || (cost_valid && cost_ready) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog expired with %0d costs outstanding", costs_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Sender: bursts of beats separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge clk)
    begin
        if (rst_n && (!node_valid || node_took))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                node_valid <= 1'b0;
            end
            else if (nodes_to_send.size() > 0)
            begin
                node <= nodes_to_send.pop_front();
                node_valid <= 1'b1;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left--;
            end
            else
                node_valid <= 1'b0;
        end
    end

    // Receiver: a randomly drawn stall pattern, redrawn periodically, plus one long hold-off.
    int stall_mode = 0;
    int stall_phase = 0;
    always @(negedge clk)
    begin
        if (stall_phase == 0)
            stall_mode = $urandom_range(0, 2);
        stall_phase = (stall_phase + 1) % 64;
        if (!hold_done && costs_checked == 20)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            cost_ready <= 1'b0;
        end
        else if (stall_mode == 0)
            cost_ready <= 1'b1;
        else if (stall_mode == 1)
            cost_ready <= $urandom_range(0, 1);
        else
            cost_ready <= ($urandom_range(0, 3) == 0);
    end

    task automatic write_reg(pdc_pkg::reg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            pdc_pkg::REG_ROBOT_X:   pos_x = longint'($signed(value[23:0]));
            pdc_pkg::REG_ROBOT_Y:   pos_y = longint'($signed(value[23:0]));
            pdc_pkg::REG_HEADING_X: dir_x = longint'($signed(value[15:0]));
            pdc_pkg::REG_HEADING_Y: dir_y = longint'($signed(value[15:0]));
            default: ;
        endcase
    endtask

    task automatic set_frame(int rx, int ry, int hx, int hy);
        write_reg(pdc_pkg::REG_ROBOT_X, 32'(rx));
        write_reg(pdc_pkg::REG_ROBOT_Y, 32'(ry));
        write_reg(pdc_pkg::REG_HEADING_X, 32'(hx));
        write_reg(pdc_pkg::REG_HEADING_Y, 32'(hy));
    endtask

    task automatic queue_node(logic [23:0] x, logic [23:0] y, logic [23:0] z, logic last);
        pdc_pkg::node_t n;
        n.node_x = x;
        n.node_y = y;
        n.node_z = z;
        n.last_node = last;
        nodes_to_send.insert(nodes_to_send.size(), n);
    endtask

    // A path either wanders near one spot or jumps across the whole range.
    task automatic push_path(int count, bit wide);
        int cx, cy, cz;
        cx = $urandom_range(0, 32'hFFFFFF) - 32'h800000;
        cy = $urandom_range(0, 32'hFFFFFF) - 32'h800000;
        cz = $urandom_range(0, 32'hFFFFFF) - 32'h800000;
        for (int i = 0; i < count; i++)
        begin
            if (wide)
                queue_node(24'($urandom), 24'($urandom), 24'($urandom), i == count - 1);
            else
                queue_node(24'(cx + $urandom_range(0, 4095) - 2048),
                           24'(cy + $urandom_range(0, 4095) - 2048),
                           24'(cz + $urandom_range(0, 1023) - 512), i == count - 1);
        end
        paths_sent++;
    endtask

    task automatic drain();
        while (nodes_to_send.size() > 0 || node_valid || costs_due.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    int rnd_budget;

    initial
    begin
        pos_x = 0;
        pos_y = 0;
        dir_x = 0;
        dir_y = 0;
        stored_nodes = 0;
        path_length = '0;
        prev_x = 0;
        prev_y = 0;
        prev_z = 0;
        extra_nodes = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: zero heading from reset, then coordinate extremes.
        queue_node(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
        queue_node(24'h800000, 24'h800000, 24'h800000, 1'b1);
        queue_node(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b0);
        queue_node(24'h800000, 24'h7FFFFF, 24'h800000, 1'b1);
        queue_node(24'h000000, 24'h000000, 24'h000000, 1'b0);
        queue_node(24'h000100, 24'h000000, 24'h000000, 1'b0);
        queue_node(24'h000200, 24'h000000, 24'h000000, 1'b1);
        paths_sent += 4;
        drain();
        set_frame(0, 0, 16384, 0);
        queue_node(24'h000100, 24'h000000, 24'h000000, 1'b0);
        queue_node(24'h000200, 24'h000000, 24'h000000, 1'b0);
        queue_node(24'h000300, 24'h000010, 24'hFFFF00, 1'b1);
        queue_node(24'h7FFFFF, 24'h7FFFFF, 24'h000000, 1'b0);
        queue_node(24'h800000, 24'h800000, 24'h000000, 1'b1);
        paths_sent += 2;
        drain();
        set_frame(8388607, -8388608, -16384, 16384);
        queue_node(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
        queue_node(24'h7FFFFF, 24'h800000, 24'h800000, 1'b0);
        queue_node(24'h800000, 24'h7FFFFF, 24'h000000, 1'b1);
        paths_sent++;
        drain();

        // Random phases, each under its own frame.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_frame(-8388608, 8388607, 16384, -16384);
                1: set_frame(0, 0, 0, 16384);
                2: set_frame(-8388608, -8388608, -16384, 0);
                default: set_frame($urandom_range(0, 32'hFFFFFF) - 32'h800000,
                                   $urandom_range(0, 32'hFFFFFF) - 32'h800000,
                                   $urandom_range(0, 32768) - 16384,
                                   $urandom_range(0, 32768) - 16384);
            endcase
            if (phase == 1)
                push_path(MAX_PATH, 1'b0);
            if (phase == 4)
                push_path(MAX_PATH + 6, 1'b1);
            rnd_budget = 80;
            while (rnd_budget > 0)
            begin
                int len;
                len = $urandom_range(1, 8);
                push_path(len, $urandom_range(0, 2) == 0);
                rnd_budget -= len;
            end
            drain();
        end

        $display("%0d paths of %0d nodes checked, %0d costs compared, frames at range limits",
                 paths_sent, nodes_taken, costs_checked);
        $display("paths covered single nodes, full-size paths and an overflowing path");
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
+incdir+design
design/pdc_pkg.sv
design/pdc_ram.sv
design/pdc_front.sv
design/pdc_queue.sv
design/pdc_back.sv
design/path_direction_dtw_cost.sv
design/pdc_checker.sv
sim/tb_path_direction_dtw_cost.sv
